>>> hw/rtl/atc_pkg.sv
// Shared types and constants for the A-trail checker.
`timescale 1ns / 1ps
package atc_pkg;

    localparam int ID_W      = 10;
    localparam int VTX_IN_W  = 9;
    localparam int SLOT_IN_W = 4;
    localparam int DEG_IN_W  = 5;
    localparam int TOTAL_W   = 14;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'd16383;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_VERIFY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        FLT_NONE = 2'd0,
        FLT_LEN  = 2'd1,
        FLT_EDGE = 2'd2,
        FLT_TURN = 2'd3
    } t_fault;

    // write enables toward the stores
    typedef struct packed {
        logic rot;
        logic deg;
        logic first;
        logic second;
        logic cnt;
        logic trail;
        logic vis;
    } t_mem_we;

    typedef struct packed {
        logic   valid_res;
        t_fault fault;
    } t_result;

endpackage

>>> hw/rtl/atc_mem.sv
// Rotation, degree, endpoint, trail and visited stores with registered reads.
`timescale 1ns / 1ps
module atc_mem #(
    parameter int MAX_VERTICES = 512,
    parameter int MAX_EDGES    = 1024,
    parameter int VW           = 9,
    parameter int EW           = 10,
    parameter int DW           = 4,
    parameter int GW           = 5
) (
    input  logic                  i_clk,
    input  atc_pkg::t_mem_we      i_we,
    input  logic [VW+DW-1:0]      i_rot_addr,
    input  logic [atc_pkg::ID_W-1:0] i_rot_wd,
    output logic [atc_pkg::ID_W-1:0] o_rot_q,
    input  logic [VW-1:0]         i_deg_addr,
    input  logic [GW-1:0]         i_deg_wd,
    output logic [GW-1:0]         o_deg_q,
    input  logic [EW-1:0]         i_ep_addr,
    input  logic [VW-1:0]         i_ep_wd,
    input  logic [1:0]            i_cnt_wd,
    output logic [VW-1:0]         o_first_q,
    output logic [VW-1:0]         o_second_q,
    output logic [1:0]            o_cnt_q,
    input  logic [EW-1:0]         i_trail_addr,
    input  logic [atc_pkg::ID_W-1:0] i_trail_wd,
    output logic [atc_pkg::ID_W-1:0] o_trail_q,
    input  logic [EW-1:0]         i_vis_addr,
    input  logic                  i_vis_wd,
    output logic                  o_vis_q
);
    import atc_pkg::*;

    localparam int ROT_DEPTH = MAX_VERTICES * (2 ** DW);

    logic [ID_W-1:0] r_rot    [ROT_DEPTH];
    logic [GW-1:0]   r_deg    [MAX_VERTICES];
    logic [VW-1:0]   r_first  [MAX_EDGES];
    logic [VW-1:0]   r_second [MAX_EDGES];
    logic [1:0]      r_cnt    [MAX_EDGES];
    logic [ID_W-1:0] r_trail  [MAX_EDGES];
    logic            r_vis    [MAX_EDGES];

    always_ff @(posedge i_clk) begin
        if (i_we.rot) begin
            r_rot[i_rot_addr] <= i_rot_wd;
        end
        o_rot_q <= r_rot[i_rot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.deg) begin
            r_deg[i_deg_addr] <= i_deg_wd;
        end
        o_deg_q <= r_deg[i_deg_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.first) begin
            r_first[i_ep_addr] <= i_ep_wd;
        end
        o_first_q <= r_first[i_ep_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.second) begin
            r_second[i_ep_addr] <= i_ep_wd;
        end
        o_second_q <= r_second[i_ep_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.cnt) begin
            r_cnt[i_ep_addr] <= i_cnt_wd;
        end
        o_cnt_q <= r_cnt[i_ep_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.trail) begin
            r_trail[i_trail_addr] <= i_trail_wd;
        end
        o_trail_q <= r_trail[i_trail_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.vis) begin
            r_vis[i_vis_addr] <= i_vis_wd;
        end
        o_vis_q <= r_vis[i_vis_addr];
    end

endmodule

>>> hw/rtl/atc_seq.sv
// Sequencer: load, append, clearing sweeps and the trail walk over the stores.
`timescale 1ns / 1ps
module atc_seq #(
    parameter int MAX_VERTICES = 512,
    parameter int MAX_EDGES    = 1024,
    parameter int MAX_DEGREE   = 16,
    parameter int VW           = 9,
    parameter int EW           = 10,
    parameter int DW           = 4,
    parameter int GW           = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  atc_pkg::t_cmd         i_cmd,
    input  logic [atc_pkg::VTX_IN_W-1:0]  i_vertex,
    input  logic [atc_pkg::SLOT_IN_W-1:0] i_slot,
    input  logic [atc_pkg::DEG_IN_W-1:0]  i_vertex_degree,
    input  logic [atc_pkg::ID_W-1:0]      i_edge_id,
    output logic                  o_res_valid,
    input  logic                  i_res_free,
    output atc_pkg::t_result      o_res,
    output atc_pkg::t_mem_we      o_we,
    output logic [VW+DW-1:0]      o_rot_addr,
    output logic [atc_pkg::ID_W-1:0] o_rot_wd,
    input  logic [atc_pkg::ID_W-1:0] i_rot_q,
    output logic [VW-1:0]         o_deg_addr,
    output logic [GW-1:0]         o_deg_wd,
    input  logic [GW-1:0]         i_deg_q,
    output logic [EW-1:0]         o_ep_addr,
    output logic [VW-1:0]         o_ep_wd,
    output logic [1:0]            o_cnt_wd,
    input  logic [VW-1:0]         i_first_q,
    input  logic [VW-1:0]         i_second_q,
    input  logic [1:0]            i_cnt_q,
    output logic [EW-1:0]         o_trail_addr,
    output logic [atc_pkg::ID_W-1:0] o_trail_wd,
    input  logic [atc_pkg::ID_W-1:0] i_trail_q,
    output logic [EW-1:0]         o_vis_addr,
    output logic                  o_vis_wd,
    input  logic                  i_vis_q
);
    import atc_pkg::*;

    localparam int LW   = $clog2(MAX_EDGES + 1);
    localparam int SMAX = (MAX_VERTICES > MAX_EDGES) ? MAX_VERTICES : MAX_EDGES;
    localparam int SW   = $clog2(SMAX);
    localparam logic [SW-1:0] CLR_LAST = SW'(SMAX - 1);
    localparam logic [SW-1:0] VIS_LAST = SW'(MAX_EDGES - 1);

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_SWEEP  = 21'h000002,
        S_LOAD0  = 21'h000004,
        S_LOAD1  = 21'h000008,
        S_APPEND = 21'h000010,
        S_V0     = 21'h000020,
        S_V1     = 21'h000040,
        S_V2     = 21'h000080,
        S_WT0    = 21'h000100,
        S_WT1    = 21'h000200,
        S_WT2    = 21'h000400,
        S_WT3    = 21'h000800,
        S_WT4    = 21'h001000,
        S_WD     = 21'h002000,
        S_WS     = 21'h004000,
        S_WF     = 21'h008000,
        S_WP     = 21'h010000,
        S_WQ     = 21'h020000,
        S_WN     = 21'h040000,
        S_FIN    = 21'h080000,
        S_OUT    = 21'h100000
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [VTX_IN_W-1:0] r_v, n_v;
    logic [SLOT_IN_W-1:0] r_slot, n_slot;
    logic [DEG_IN_W-1:0] r_deg, n_deg;
    logic [ID_W-1:0]     r_e, n_e;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_i, n_i;
    logic [ID_W-1:0]     r_ecur, n_ecur;
    logic [ID_W-1:0]     r_ne, n_ne;
    logic [VW-1:0]       r_cur, n_cur;
    logic [VW-1:0]       r_alt, n_alt;
    logic [GW-1:0]       r_d, n_d;
    logic [GW-1:0]       r_loc, n_loc;
    logic                r_eul, n_eul;
    logic                r_round, n_round;
    logic                r_mpre, n_mpre;
    t_fault              r_fault, n_fault;
    logic [SW-1:0]       r_sw, n_sw;
    logic                r_sclr, n_sclr;

    logic [TOTAL_W-2:0]  edge_cnt;
    logic [LW-1:0]       i_next;
    logic [GW-1:0]       loc_next;
    logic [GW-1:0]       loc_pre;
    logic [GW-1:0]       loc_suc;
    logic [DEG_IN_W-1:0] deg_sat;

    function automatic logic f_bad(logic [ID_W-1:0] e, logic [1:0] cnt,
                                   logic [TOTAL_W-2:0] m);
        f_bad = (32'(e) >= 32'(m)) || (32'(e) >= MAX_EDGES) || (cnt < 2'd2);
    endfunction

    assign edge_cnt = r_total[TOTAL_W-1:1];
    assign i_next   = r_i + LW'(1);
    assign loc_next = r_loc + GW'(1);
    assign loc_pre  = (r_loc == r_d - GW'(1)) ? '0 : loc_next;
    assign loc_suc  = (r_loc == '0) ? (r_d - GW'(1)) : (r_loc - GW'(1));
    assign deg_sat  = (32'(r_deg) > MAX_DEGREE) ? DEG_IN_W'(MAX_DEGREE) : r_deg;

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res.valid_res = (r_fault == FLT_NONE);
    assign o_res.fault     = r_fault;

    assign o_rot_wd   = r_e;
    assign o_deg_wd   = (r_state == S_SWEEP) ? '0 : GW'(deg_sat);
    assign o_ep_wd    = VW'(r_v);
    assign o_trail_wd = r_e;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_v     = r_v;
        n_slot  = r_slot;
        n_deg   = r_deg;
        n_e     = r_e;
        n_total = r_total;
        n_len   = r_len;
        n_i     = r_i;
        n_ecur  = r_ecur;
        n_ne    = r_ne;
        n_cur   = r_cur;
        n_alt   = r_alt;
        n_d     = r_d;
        n_loc   = r_loc;
        n_eul   = r_eul;
        n_round = r_round;
        n_mpre  = r_mpre;
        n_fault = r_fault;
        n_sw    = r_sw;
        n_sclr  = r_sclr;

        o_we         = '0;
        o_rot_addr   = {r_cur, DW'(r_loc)};
        o_deg_addr   = r_cur;
        o_ep_addr    = EW'(r_e);
        o_cnt_wd     = '0;
        o_trail_addr = EW'(r_i);
        o_vis_addr   = EW'(r_ecur);
        o_vis_wd     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = i_cmd;
                    n_v    = i_vertex;
                    n_slot = i_slot;
                    n_deg  = i_vertex_degree;
                    n_e    = i_edge_id;
                    case (i_cmd)
                        CMD_CLEAR: begin
                            n_len   = '0;
                            n_total = '0;
                            n_sw    = '0;
                            n_sclr  = 1'b1;
                            n_state = S_SWEEP;
                        end
                        CMD_LOAD:   n_state = S_LOAD0;
                        CMD_APPEND: n_state = S_APPEND;
                        default:    n_state = S_V0;
                    endcase
                end
            end
            S_SWEEP: begin
                o_deg_addr = VW'(r_sw);
                o_ep_addr  = EW'(r_sw);
                o_vis_addr = EW'(r_sw);
                o_we.vis   = (32'(r_sw) < MAX_EDGES);
                if (r_sclr) begin
                    o_we.deg = (32'(r_sw) < MAX_VERTICES);
                    o_we.cnt = (32'(r_sw) < MAX_EDGES);
                    if (r_sw == CLR_LAST) begin
                        n_state = S_IDLE;
                    end
                end else if (r_sw == VIS_LAST) begin
                    n_state = S_WT0;
                end
                n_sw = r_sw + SW'(1);
            end
            S_LOAD0: begin
                if (32'(r_v) >= MAX_VERTICES) begin
                    n_state = S_IDLE;
                end else begin
                    o_deg_addr = VW'(r_v);
                    o_we.deg   = 1'b1;
                    o_rot_addr = {VW'(r_v), DW'(r_slot)};
                    o_we.rot   = (32'(r_slot) < MAX_DEGREE);
                    if (r_total < TOTAL_MAX) begin
                        n_total = r_total + TOTAL_W'(1);
                    end
                    n_state = S_LOAD1;
                end
            end
            S_LOAD1: begin
                // record the first two endpoints of the edge in load order
                if (32'(r_e) < MAX_EDGES) begin
                    if (i_cnt_q == 2'd0) begin
                        o_we.first = 1'b1;
                        o_we.cnt   = 1'b1;
                        o_cnt_wd   = 2'd1;
                    end else if (i_cnt_q == 2'd1) begin
                        o_we.second = 1'b1;
                        o_we.cnt    = 1'b1;
                        o_cnt_wd    = 2'd2;
                    end
                end
                n_state = S_IDLE;
            end
            S_APPEND: begin
                o_trail_addr = EW'(r_len);
                if (32'(r_len) < MAX_EDGES) begin
                    o_we.trail = 1'b1;
                    n_len      = r_len + LW'(1);
                end
                n_state = S_IDLE;
            end
            S_V0: begin
                o_trail_addr = '0;
                if ((32'(r_len) != 32'(edge_cnt)) || (edge_cnt == '0)) begin
                    n_fault = FLT_LEN;
                    n_state = S_FIN;
                end else begin
                    n_state = S_V1;
                end
            end
            S_V1: begin
                n_ecur    = i_trail_q;
                o_ep_addr = EW'(i_trail_q);
                n_state   = S_V2;
            end
            S_V2: begin
                if (f_bad(r_ecur, i_cnt_q, edge_cnt)) begin
                    n_fault = FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    n_cur   = i_second_q;
                    n_alt   = i_first_q;
                    n_round = 1'b0;
                    n_i     = '0;
                    n_eul   = 1'b1;
                    n_sw    = '0;
                    n_sclr  = 1'b0;
                    n_state = S_SWEEP;
                end
            end
            S_WT0: begin
                n_state = S_WT1;
            end
            S_WT1: begin
                n_ecur       = i_trail_q;
                o_trail_addr = (i_next < r_len) ? EW'(i_next) : '0;
                n_state      = S_WT2;
            end
            S_WT2: begin
                n_ne       = i_trail_q;
                o_ep_addr  = EW'(r_ecur);
                o_vis_addr = EW'(r_ecur);
                n_state    = S_WT3;
            end
            S_WT3: begin
                o_ep_addr = EW'(r_ne);
                if (f_bad(r_ecur, i_cnt_q, edge_cnt)) begin
                    n_fault = FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    if (i_vis_q) begin
                        n_eul = 1'b0;
                    end
                    o_we.vis = 1'b1;
                    o_vis_wd = 1'b1;
                    n_state  = S_WT4;
                end
            end
            S_WT4: begin
                if (f_bad(r_ne, i_cnt_q, edge_cnt)) begin
                    n_fault = FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    n_state = S_WD;
                end
            end
            S_WD: begin
                n_d        = i_deg_q;
                n_loc      = '0;
                o_rot_addr = {r_cur, DW'(0)};
                if (i_deg_q == '0) begin
                    n_fault = r_eul ? FLT_TURN : FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    n_state = S_WS;
                end
            end
            S_WS: begin
                // scan one slot per cycle for the current edge
                o_rot_addr = {r_cur, DW'(loc_next)};
                if (i_rot_q == r_ecur) begin
                    n_state = S_WF;
                end else if (loc_next >= r_d) begin
                    n_fault = r_eul ? FLT_TURN : FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    n_loc = loc_next;
                end
            end
            S_WF: begin
                o_rot_addr = {r_cur, DW'(loc_pre)};
                n_state    = S_WP;
            end
            S_WP: begin
                n_mpre     = (i_rot_q == r_ne);
                o_rot_addr = {r_cur, DW'(loc_suc)};
                n_state    = S_WQ;
            end
            S_WQ: begin
                o_ep_addr = EW'(r_ne);
                if (!r_mpre && (i_rot_q != r_ne)) begin
                    n_fault = r_eul ? FLT_TURN : FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    n_state = S_WN;
                end
            end
            S_WN: begin
                n_cur = (i_first_q == r_cur) ? i_second_q : i_first_q;
                n_i   = i_next;
                if (i_next == r_len) begin
                    n_fault = r_eul ? FLT_NONE : FLT_EDGE;
                    n_state = S_FIN;
                end else begin
                    n_state = S_WT0;
                end
            end
            S_FIN: begin
                // retry once from the other endpoint after a failed turn
                if ((r_fault == FLT_TURN) && !r_round) begin
                    n_round = 1'b1;
                    n_cur   = r_alt;
                    n_i     = '0;
                    n_eul   = 1'b1;
                    n_sw    = '0;
                    n_sclr  = 1'b0;
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sclr  <= 1'b1;
            r_sw    <= '0;
            r_len   <= '0;
            r_total <= '0;
            r_fault <= FLT_NONE;
        end else begin
            r_state <= n_state;
            r_sclr  <= n_sclr;
            r_sw    <= n_sw;
            r_len   <= n_len;
            r_total <= n_total;
            r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_v     <= n_v;
        r_slot  <= n_slot;
        r_deg   <= n_deg;
        r_e     <= n_e;
        r_i     <= n_i;
        r_ecur  <= n_ecur;
        r_ne    <= n_ne;
        r_cur   <= n_cur;
        r_alt   <= n_alt;
        r_d     <= n_d;
        r_loc   <= n_loc;
        r_eul   <= n_eul;
        r_round <= n_round;
        r_mpre  <= n_mpre;
    end

endmodule

>>> hw/rtl/a_trail_checker_top.sv
// Top level of the A-trail checker: stream ports, output register, store and sequencer.
//
//  channel | dir | handshake              | word
//  s       | in  | i_s_tvalid/o_s_tready  | cmd, vertex, slot, vertex_degree, edge_id
//  m       | out | o_m_tvalid/i_m_tready  | valid_res, fault
//
//  Clear word: one pass over max(MAX_VERTICES, MAX_EDGES) entries.
//  Load word: writes the degree and rotation slot, then records the edge endpoint; append word: writes one trail entry.
//  Verify word: a pass over the MAX_EDGES visited marks per round, then for each trail edge a scan
//  of the rotation slots at the current vertex; the rotation store's single read port sets
//  the pace.
//  Reset runs the same pass as a clear word; o_s_tready stays low during it.
//  A result held in the output register does not stop the next word from being taken.
`timescale 1ns / 1ps
module a_trail_checker_top #(
    parameter int MAX_VERTICES = 512,
    parameter int MAX_EDGES    = 1024,
    parameter int MAX_DEGREE   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] cmd, [10:2] vertex, [14:11] slot, [19:15] vertex_degree, [29:20] edge_id
    input  logic [atc_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] valid_res, [2:1] fault
    output logic [atc_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import atc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW = $clog2(MAX_DEGREE);
    localparam int GW = $clog2(MAX_DEGREE + 1);

    t_mem_we            we;
    logic [VW+DW-1:0]   rot_addr;
    logic [ID_W-1:0]    rot_wd, rot_q;
    logic [VW-1:0]      deg_addr;
    logic [GW-1:0]      deg_wd, deg_q;
    logic [EW-1:0]      ep_addr;
    logic [VW-1:0]      ep_wd, first_q, second_q;
    logic [1:0]         cnt_wd, cnt_q;
    logic [EW-1:0]      trail_addr;
    logic [ID_W-1:0]    trail_wd, trail_q;
    logic [EW-1:0]      vis_addr;
    logic               vis_wd, vis_q;
    logic               res_valid, res_free;
    t_result            res;
    logic               r_ov;
    t_result            r_res;

    assign res_free   = !r_ov || i_m_tready;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(M_TDATA_W - 3){1'b0}}, r_res.fault, r_res.valid_res};

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_free) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_res <= res;
        end
    end

    atc_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .MAX_DEGREE   (MAX_DEGREE),
        .VW           (VW),
        .EW           (EW),
        .DW           (DW),
        .GW           (GW)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_cmd           (t_cmd'(i_s_tdata[1:0])),
        .i_vertex        (i_s_tdata[10:2]),
        .i_slot          (i_s_tdata[14:11]),
        .i_vertex_degree (i_s_tdata[19:15]),
        .i_edge_id       (i_s_tdata[29:20]),
        .o_res_valid     (res_valid),
        .i_res_free      (res_free),
        .o_res           (res),
        .o_we            (we),
        .o_rot_addr      (rot_addr),
        .o_rot_wd        (rot_wd),
        .i_rot_q         (rot_q),
        .o_deg_addr      (deg_addr),
        .o_deg_wd        (deg_wd),
        .i_deg_q         (deg_q),
        .o_ep_addr       (ep_addr),
        .o_ep_wd         (ep_wd),
        .o_cnt_wd        (cnt_wd),
        .i_first_q       (first_q),
        .i_second_q      (second_q),
        .i_cnt_q         (cnt_q),
        .o_trail_addr    (trail_addr),
        .o_trail_wd      (trail_wd),
        .i_trail_q       (trail_q),
        .o_vis_addr      (vis_addr),
        .o_vis_wd        (vis_wd),
        .i_vis_q         (vis_q)
    );

    atc_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VW           (VW),
        .EW           (EW),
        .DW           (DW),
        .GW           (GW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_we         (we),
        .i_rot_addr   (rot_addr),
        .i_rot_wd     (rot_wd),
        .o_rot_q      (rot_q),
        .i_deg_addr   (deg_addr),
        .i_deg_wd     (deg_wd),
        .o_deg_q      (deg_q),
        .i_ep_addr    (ep_addr),
        .i_ep_wd      (ep_wd),
        .i_cnt_wd     (cnt_wd),
        .o_first_q    (first_q),
        .o_second_q   (second_q),
        .o_cnt_q      (cnt_q),
        .i_trail_addr (trail_addr),
        .i_trail_wd   (trail_wd),
        .o_trail_q    (trail_q),
        .i_vis_addr   (vis_addr),
        .i_vis_wd     (vis_wd),
        .o_vis_q      (vis_q)
    );

endmodule

>>> hw/rtl/atc_chk.sv
// Port-level checks for the A-trail checker and their bind to the top level.
`timescale 1ns / 1ps
module atc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // result word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

    // success flag agrees with the fault code
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[2:1] == 2'd0)))
        else $error("valid_res disagrees with fault");

    // the clearing pass after reset keeps the input closed
    a_rst: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_s_tready)
        else $error("ready during clearing pass");

    // ready is low in the cycle after a word is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after an accepted word");

endmodule

bind a_trail_checker_top atc_chk u_atc_chk (.*);

>>> verif/testbench.sv
// Self-checking stream testbench for the A-trail checker, with its own trail-walk predictor.
`timescale 1ns / 1ps
module testbench;
    import atc_pkg::*;

    localparam int NV = 512;
    localparam int NE = 1024;
    localparam int ND = 16;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;

    a_trail_checker_top u_top (
        .i_clk     (i_clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_valid),
        .o_s_tready(s_ready),
        .i_s_tdata (s_data),
        .o_m_tvalid(m_valid),
        .i_m_tready(m_ready),
        .o_m_tdata (m_data)
    );

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // shadow copy of the block's stores
    logic [9:0] rot_mem [NV*ND];
    bit         rot_wr  [NV*ND];
    int         deg_mem [NV];
    int         ep_a    [NE];
    int         ep_b    [NE];
    int         ep_n    [NE];
    int         trail_mem [NE];
    int         trail_len;
    int         load_total;

    t_result    verdict_q[$];
    int         err_cnt;
    int         words_sent;
    int         verifies_sent;
    int         burst_left;
    int         hold_req;
    int         hold_left;
    int         rx_mode;
    int         rx_phase;

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic bit edge_bad(int e, int m);
        return e >= m || e >= NE || ep_n[e] < 2;
    endfunction

    function automatic t_fault walk_round(int start, int len, int m);
        bit seen [NE];
        int cur;
        int e;
        int ne;
        int d;
        int loc;
        int pre;
        int suc;
        int base;
        bit euler;
        cur = start;
        euler = 1'b1;
        for (int i = 0; i < len; i++) begin
            e = trail_mem[i];
            ne = trail_mem[(i + 1 < len) ? i + 1 : 0];
            if (edge_bad(e, m) || edge_bad(ne, m)) return FLT_EDGE;
            if (seen[e]) euler = 1'b0;
            seen[e] = 1'b1;
            d = deg_mem[cur];
            base = cur * ND;
            for (loc = 0; loc < d; loc++)
                if (rot_mem[base + loc] == e[9:0]) break;
            if (loc >= d) return euler ? FLT_TURN : FLT_EDGE;
            pre = (loc == d - 1) ? 0 : loc + 1;
            suc = (loc == 0) ? d - 1 : loc - 1;
            if (rot_mem[base + pre] != ne[9:0] && rot_mem[base + suc] != ne[9:0])
                return euler ? FLT_TURN : FLT_EDGE;
            cur = (ep_a[ne] == cur) ? ep_b[ne] : ep_a[ne];
        end
        return euler ? FLT_NONE : FLT_EDGE;
    endfunction

    function automatic t_fault trail_verdict();
        int m;
        t_fault f;
        m = load_total >> 1;
        if (trail_len != m || m == 0) return FLT_LEN;
        if (edge_bad(trail_mem[0], m)) return FLT_EDGE;
        f = walk_round(ep_b[trail_mem[0]], trail_len, m);
        if (f != FLT_TURN) return f;
        return walk_round(ep_a[trail_mem[0]], trail_len, m);
    endfunction

    // every slot below a degree must have been written before a walk reads it
    function automatic bit rotation_safe();
        for (int v = 0; v < NV; v++)
            for (int s = 0; s < deg_mem[v]; s++)
                if (!rot_wr[v*ND + s]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int written_prefix(int v);
        int n;
        n = 0;
        while (n < ND && rot_wr[v*ND + n]) n++;
        return n;
    endfunction

    function automatic void apply_word(t_cmd c, int v, int s, int d, int e);
        t_result r;
        case (c)
            CMD_CLEAR: begin
                foreach (deg_mem[i]) deg_mem[i] = 0;
                foreach (ep_n[i]) ep_n[i] = 0;
                trail_len = 0;
                load_total = 0;
            end
            CMD_LOAD: begin
                deg_mem[v] = (d > ND) ? ND : d;
                rot_mem[v*ND + s] = e[9:0];
                rot_wr[v*ND + s] = 1'b1;
                if (ep_n[e] == 0) begin
                    ep_a[e] = v;
                    ep_n[e] = 1;
                end else if (ep_n[e] == 1) begin
                    ep_b[e] = v;
                    ep_n[e] = 2;
                end
                if (load_total < int'(TOTAL_MAX)) load_total++;
            end
            CMD_APPEND: begin
                if (trail_len < NE) begin
                    trail_mem[trail_len] = e;
                    trail_len++;
                end
            end
            default: begin
                r.fault = trail_verdict();
                r.valid_res = (r.fault == FLT_NONE);
                verdict_q.insert(verdict_q.size(), r);
            end
        endcase
    endfunction

    task automatic send_word(t_cmd c, int v, int s, int d, int e);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {2'b00, e[9:0], d[4:0], s[3:0], v[8:0], c};
        do @(posedge i_clk); while (!s_ready);
        apply_word(c, v, s, d, e);
        words_sent++;
        if (c == CMD_VERIFY) verifies_sent++;
    endtask

    task automatic send_verify();
        if (rotation_safe()) send_word(CMD_VERIFY, 0, 0, 0, 0);
    endtask

    // drop the offer, then wait for every expected result
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // Loads a set of cycles sharing one hub vertex and a trail that walks them in rotation
    // order, then optionally breaks the trail.
    task automatic send_trail_graph(bit perturb);
        int k;
        int n_e;
        int hub;
        int lens [8];
        int ids [$];
        int trail [$];
        int hub_rot [$];
        int lv [$];
        int ls [$];
        int ld [$];
        int le [$];
        bit used [NV];
        int x;
        int prv;
        int nxt;
        int t;
        int j;
        int sh;
        k = $urandom_range(1, 8);
        n_e = 0;
        for (int i = 0; i < k; i++) begin
            lens[i] = $urandom_range(2, (k > 4) ? 2 : 5);
            n_e += lens[i];
        end
        for (int i = 0; i < n_e; i++) ids.insert(ids.size(), i);
        for (int i = n_e - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ids[i]; ids[i] = ids[j]; ids[j] = t;
        end
        hub = $urandom_range(0, NV - 1);
        used[hub] = 1'b1;
        t = 0;
        for (int i = 0; i < k; i++) begin
            hub_rot.insert(hub_rot.size(), ids[t]);
            hub_rot.insert(hub_rot.size(), ids[t + lens[i] - 1]);
            for (int p = 1; p < lens[i]; p++) begin
                do x = $urandom_range(0, NV - 1); while (used[x]);
                used[x] = 1'b1;
                prv = ids[t + p - 1];
                nxt = ids[t + p];
                sh = $urandom_range(0, 1);
                lv.insert(lv.size(), x);
                ls.insert(ls.size(), sh);
                ld.insert(ld.size(), 2);
                le.insert(le.size(), prv);
                lv.insert(lv.size(), x);
                ls.insert(ls.size(), 1 - sh);
                ld.insert(ld.size(), 2);
                le.insert(le.size(), nxt);
            end
            for (int p = 0; p < lens[i]; p++) trail.insert(trail.size(), ids[t + p]);
            t += lens[i];
        end
        sh = $urandom_range(0, 2*k - 1);
        for (int i = 0; i < 2*k; i++) begin
            lv.insert(lv.size(), hub);
            ls.insert(ls.size(), (i + sh) % (2*k));
            ld.insert(ld.size(), 2*k);
            le.insert(le.size(), hub_rot[i]);
        end
        for (int i = lv.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = lv[i]; lv[i] = lv[j]; lv[j] = t;
            t = ls[i]; ls[i] = ls[j]; ls[j] = t;
            t = le[i]; le[i] = le[j]; le[j] = t;
            t = ld[i]; ld[i] = ld[j]; ld[j] = t;
        end
        foreach (lv[i]) send_word(CMD_LOAD, lv[i], ls[i], ld[i], le[i]);
        sh = $urandom_range(0, n_e - 1);
        for (int i = 0; i < sh; i++) begin
            t = trail.pop_front();
            trail.insert(trail.size(), t);
        end
        if ($urandom_range(0, 1)) trail.reverse();
        if (perturb) begin
            case ($urandom_range(0, 4))
                0: begin
                    j = $urandom_range(0, n_e - 1);
                    x = $urandom_range(0, n_e - 1);
                    t = trail[j]; trail[j] = trail[x]; trail[x] = t;
                end
                1: trail[$urandom_range(0, n_e - 1)] = $urandom_range(0, NE - 1);
                2: trail.pop_back();
                3: trail[$urandom_range(0, n_e - 1)] = trail[$urandom_range(0, n_e - 1)];
                default: begin
                    j = $urandom_range(0, NV - 1);
                    x = written_prefix(j);
                    t = $urandom_range(0, ND - 1);
                    if (t == x) x++;
                    send_word(CMD_LOAD, j, t, $urandom_range(0, x), $urandom_range(0, NE - 1));
                end
            endcase
        end
        foreach (trail[i]) send_word(CMD_APPEND, 0, 0, 0, trail[i]);
    endtask

    task automatic test_directed();
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_verify();
        send_word(CMD_LOAD, 0, 0, 2, 0);
        send_word(CMD_LOAD, 0, 1, 2, 1);
        send_word(CMD_LOAD, NV - 1, 0, 2, 1);
        send_word(CMD_LOAD, NV - 1, 1, 2, 0);
        send_word(CMD_APPEND, 0, 0, 0, 0);
        send_word(CMD_APPEND, 0, 0, 0, 1);
        send_verify();
        send_word(CMD_APPEND, 0, 0, 0, 0);
        send_verify();
        // saturated degree and out-of-range edge, then drop the degree again
        send_word(CMD_LOAD, 9, ND - 1, 31, NE - 1);
        send_word(CMD_LOAD, 9, ND - 1, 0, NE - 1);
        send_verify();
        // third endpoint of edge 0 is kept out
        send_word(CMD_LOAD, 3, 0, 1, 0);
        send_word(CMD_APPEND, 0, 0, 0, NE - 1);
        send_verify();
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_word(CMD_LOAD, 4, 0, 1, 0);
        send_word(CMD_LOAD, 4, 0, 1, 0);
        send_word(CMD_APPEND, 0, 0, 0, 0);
        send_verify();
        wait_results();
    endtask

    task automatic test_backpressure();
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_trail_graph(1'b0);
        hold_req = 3000;
        repeat (4) send_verify();
        wait_results();
    endtask

    task automatic test_random();
        while (words_sent < 1300 || verifies_sent < 60) begin
            send_word(CMD_CLEAR, 0, 0, 0, 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: loose loads and appends with no structure
                repeat ($urandom_range(1, 12)) begin
                    int v;
                    int s;
                    int p;
                    v = $urandom_range(0, NV - 1);
                    s = $urandom_range(0, ND - 1);
                    p = written_prefix(v);
                    if (s == p) p++;
                    if ($urandom_range(0, 2) == 0)
                        send_word(CMD_APPEND, 0, 0, 0, $urandom_range(0, NE - 1));
                    else
                        send_word(CMD_LOAD, v, s, $urandom_range(0, p),
                                  $urandom_range(0, NE - 1));
                end
            end else begin
                send_trail_graph($urandom_range(0, 9) < 4);
            end
            send_verify();
            if ($urandom_range(0, 3) == 0) send_verify();
            if ($urandom_range(0, 4) == 0) wait_results();
        end
    endtask

    // receiver: random ready pattern in phases, with an on-demand long hold
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_phase = $urandom_range(10, 200);
            end
            rx_phase--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report("unexpected word, fault", m_data[2:1], -1);
            end else begin
                want = verdict_q.pop_front();
                if (m_data[0] != want.valid_res) report("valid_res", m_data[0], want.valid_res);
                if (m_data[2:1] != want.fault) report("fault", m_data[2:1], want.fault);
            end
        end
    end

    initial begin
        err_cnt = 0;
        words_sent = 0;
        verifies_sent = 0;
        burst_left = 0;
        hold_req = 0;
        hold_left = 0;
        rx_phase = 0;
        trail_len = 0;
        load_total = 0;
        foreach (deg_mem[i]) deg_mem[i] = 0;
        foreach (ep_n[i]) ep_n[i] = 0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        wait_results();
        repeat (2500) @(posedge i_clk);
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/atc_pkg.sv
hw/rtl/atc_mem.sv
hw/rtl/atc_seq.sv
hw/rtl/a_trail_checker_top.sv
hw/rtl/atc_chk.sv
verif/testbench.sv
